// ----- design/parq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// parq_pkg
// shared types and constants of the pending ack retransmit table
// ----------------------------------------------------------------------------
package parq_pkg;
  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_STORED    = 3'd0,
    KIND_DROPPED   = 3'd1,
    KIND_ACKED     = 3'd2,
    KIND_UNMATCHED = 3'd3,
    KIND_RESEND    = 3'd4
  } kind_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] seq;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic        ready;
  } hs_t;
endpackage
`default_nettype wire

// ----- design/parq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// parq_front
// accepts items, drops unused codes, queues commands for the back end
// ----------------------------------------------------------------------------
module parq_front import parq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_seq,
  output hs_t              q_hs,
  input  wire logic        q_pop,
  output cmd_t             q_cmd
);
  localparam int QW = $clog2(QDepth);
  cmd_t         mem_r [QDepth];
  logic [QW:0]  cnt_r, cnt_nxt;
  logic [QW-1:0] wp_r, rp_r;
  logic push, keep;

  assign in_ready = (cnt_r != QW'(0) + (QW+1)'(QDepth)) ? 1'b1 : 1'b0;
  // unused function code is swallowed here
  assign keep = (func_t'(in_func) != FUNC_NONE);
  assign push = in_valid && in_ready && keep;
  assign q_hs.valid = (cnt_r != '0);
  assign q_hs.ready = in_ready;
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + (QW+1)'(push) - (QW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= '0; rp_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
    end
    if (push) mem_r[wp_r] <= '{func: func_t'(in_func), seq: in_seq};
  end
endmodule
`default_nettype wire

// ----- design/parq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// parq_back
// table storage and sequencer for send, ack and tick commands
// ----------------------------------------------------------------------------
module parq_back import parq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  cmd_t             q_cmd,
  input  wire logic [15:0] timeout,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_seq,
  output logic             out_last,
  output logic             busy
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_ACK = 4'b0010, ST_SHIFT = 4'b0100, ST_TICK = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  logic [31:0] seq_r [TableDepth];
  logic [31:0] tim_r [TableDepth];
  logic [CntW-1:0] cnt_r;
  logic [31:0] now_r, cseq_r;
  logic [CntW-1:0] i_r;
  logic [IdxW-1:0] ix;
  logic ov_r, pend_r;      // out valid, and a held resend awaiting last info
  logic [2:0] ok_r;
  logic [31:0] os_r;
  logic ol_r;
  logic [31:0] pseq_r;
  logic out_free, emit;
  logic [2:0] ekind; logic [31:0] eseq; logic elast;
  logic [31:0] age;
  logic hit, at_end;

  assign ix = i_r[IdxW-1:0];
  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_seq = os_r;
  assign out_last = ol_r;
  assign out_free = !ov_r || out_ready;
  assign busy = (st_r != ST_IDLE) || ov_r || pend_r;
  assign age = now_r - tim_r[ix];
  assign hit = age > {16'd0, timeout};
  assign at_end = (i_r + CntW'(1) >= cnt_r);

  always_comb begin
    st_nxt = st_r; q_pop = 1'b0; emit = 1'b0;
    ekind = KIND_STORED; eseq = cseq_r; elast = 1'b1;
    case (st_r)
      ST_IDLE: if (q_valid && out_free && !pend_r) begin
        q_pop = 1'b1;
        case (q_cmd.func)
          FUNC_SEND: begin
            emit = 1'b1; eseq = q_cmd.seq;
            ekind = (cnt_r < CntW'(TableDepth)) ? KIND_STORED : KIND_DROPPED;
          end
          FUNC_ACK: st_nxt = (cnt_r == '0) ? ST_IDLE : ST_ACK;
          FUNC_TICK: st_nxt = (cnt_r == '0) ? ST_IDLE : ST_TICK;
          default: st_nxt = ST_IDLE;
        endcase
        if (q_cmd.func == FUNC_ACK && cnt_r == '0) begin
          emit = 1'b1; ekind = KIND_UNMATCHED; eseq = q_cmd.seq;
        end
      end
      ST_ACK: if (seq_r[ix] == cseq_r) begin
        if (out_free) begin
          emit = 1'b1; ekind = KIND_ACKED;
          st_nxt = ST_SHIFT;
        end
      end else if (at_end) begin
        if (out_free) begin
          emit = 1'b1; ekind = KIND_UNMATCHED; st_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: if (at_end) st_nxt = ST_IDLE;
      ST_TICK: begin
        // a pending resend goes out with last=0 once another hit shows up
        if (hit && pend_r) begin
          if (out_free) begin
            emit = 1'b1; ekind = KIND_RESEND; eseq = pseq_r; elast = 1'b0;
            if (at_end) st_nxt = ST_IDLE;
          end
        end else if (at_end) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    // flush the held resend as last at the end of a tick scan
    if (st_r == ST_IDLE && pend_r && out_free) begin
      emit = 1'b1; ekind = KIND_RESEND; eseq = pseq_r; elast = 1'b1;
    end
  end

  logic adv;
  always_comb begin
    adv = 1'b0;
    case (st_r)
      ST_ACK: adv = (seq_r[ix] != cseq_r) && !at_end;
      ST_SHIFT: adv = 1'b1;
      ST_TICK: adv = !(hit && pend_r) || out_free;
      default: adv = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; now_r <= '0; i_r <= '0;
      ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (st_r == ST_IDLE && pend_r && out_free) pend_r <= 1'b0;
      if (st_r == ST_IDLE) i_r <= '0;
      else if (adv && !at_end) i_r <= i_r + CntW'(1);
      if (q_pop && q_cmd.func == FUNC_SEND && cnt_r < CntW'(TableDepth))
        cnt_r <= cnt_r + CntW'(1);
      if (q_pop && q_cmd.func == FUNC_TICK) now_r <= now_r + 32'd1;
      if (st_r == ST_ACK && st_nxt == ST_SHIFT) cnt_r <= cnt_r - CntW'(1);
      if (st_r == ST_TICK && adv && hit) pend_r <= 1'b1;
    end
    if (q_pop) cseq_r <= q_cmd.seq;
    if (emit) begin
      ok_r <= ekind; os_r <= eseq; ol_r <= elast;
    end
    if (q_pop && q_cmd.func == FUNC_SEND && cnt_r < CntW'(TableDepth)) begin
      seq_r[cnt_r[IdxW-1:0]] <= q_cmd.seq;
      tim_r[cnt_r[IdxW-1:0]] <= now_r;
    end
    // count is already reduced here, so each slot from the acked one up to below it takes its successor
    if (st_r == ST_SHIFT && i_r < cnt_r) begin
      seq_r[ix] <= seq_r[ix + IdxW'(1)];
      tim_r[ix] <= tim_r[ix + IdxW'(1)];
    end
    if (st_r == ST_TICK && adv && hit) begin
      tim_r[ix] <= now_r; pseq_r <= seq_r[ix];
    end
  end
endmodule
`default_nettype wire

// ----- design/pending_ack_retransmit_table_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pending_ack_retransmit_table_unit
// ordered table of unacknowledged sequence numbers with resend timer
// ----------------------------------------------------------------------------
// send path: an accepted item is queued in the front end, then its result is registered at the back-end output
// ack: back end busy for the pop, a search of one entry per cycle, then compaction
// tick: one entry per cycle while the output does not stall, one resend held back
// the single back-end sequencer takes a new command only when it is back in its idle state
// reset: synchronous active low; table contents stay undefined, count and time cleared
module pending_ack_retransmit_table_unit import parq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // func[1:0], seq[33:2], zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // kind[2:0], seq_out[34:3], zero pad
  output logic             out_tlast,  // last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // timeout_ticks
);
  hs_t  q_hs;
  cmd_t q_cmd;
  logic q_pop, busy;
  logic [15:0] timeout_r;
  logic [2:0]  kind;
  logic [31:0] seq_o;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= 16'd1000;
    else if (cfg_valid) timeout_r <= cfg_data;
  end

  parq_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_func(in_tdata[1:0]), .in_seq(in_tdata[33:2]),
    .q_hs, .q_pop, .q_cmd
  );

  parq_back u_back (
    .clk, .rst_n, .q_valid(q_hs.valid), .q_pop, .q_cmd, .timeout(timeout_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_kind(kind),
    .out_seq(seq_o), .out_last(out_tlast), .busy
  );

  assign out_tdata = {5'd0, seq_o, kind};

  // never pop an empty queue
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_hs.valid)
    else $error("pop from empty queue");
  // result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  // a visible result keeps the back end busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> busy)
    else $error("busy low with result");
endmodule
`default_nettype wire

// ----- bench/pending_ack_retransmit_table_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_ack_retransmit_table_unit_tb
// self-checking bench: sends, acks and ticks against a predicted table and timer
// ----------------------------------------------------------------------------
module pending_ack_retransmit_table_unit_tb;
  import parq_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  pending_ack_retransmit_table_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // func[1:0], seq[33:2], zero pad
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // kind[2:0], seq_out[34:3], zero pad
    .out_tlast  (out_tlast),  // last
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)    // timeout_ticks
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // predicted block state
  logic [31:0] pend_seq [TableDepth];
  logic [31:0] pend_time [TableDepth];
  int          pend_count;
  logic [31:0] tick_now;
  logic [15:0] timeout_reg;

  cmd_t    cmd_queue [$];
  result_t expected_results [$];
  int      errors;

  // recent sends, so that acks mostly hit
  logic [31:0] sent_pool [$];

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // advances the predicted table by one command and queues its results
  task automatic predict_table(input cmd_t c);
    result_t r;
    int      hit;
    int      n;
    hit = -1;
    n   = 0;
    case (c.func)
      FUNC_SEND: begin
        if (pend_count < TableDepth) begin
          pend_seq[pend_count]  = c.seq;
          pend_time[pend_count] = tick_now;
          pend_count++;
          r = '{KIND_STORED, c.seq, 1'b1};
        end else begin
          r = '{KIND_DROPPED, c.seq, 1'b1};
        end
        expected_results.push_back(r);
      end
      FUNC_ACK: begin
        for (int i = 0; i < pend_count; i++)
          if (hit < 0 && pend_seq[i] == c.seq) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j + 1 < pend_count; j++) begin
            pend_seq[j]  = pend_seq[j+1];
            pend_time[j] = pend_time[j+1];
          end
          pend_count--;
          r = '{KIND_ACKED, c.seq, 1'b1};
        end else begin
          r = '{KIND_UNMATCHED, c.seq, 1'b1};
        end
        expected_results.push_back(r);
      end
      FUNC_TICK: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < pend_count; i++) begin
          if (32'(tick_now - pend_time[i]) > {16'd0, timeout_reg}) begin
            expected_results.push_back('{KIND_RESEND, pend_seq[i], 1'b0});
            pend_time[i] = tick_now;
            n++;
          end
        end
        // only the final resend of a tick carries last
        if (n > 0) expected_results[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // driver: one item at a time from the pending queue, random gaps
  int gap_in;
  always @(posedge clk) begin
    cmd_t nxt;
    cmd_t got;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_in    <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold until accepted
    end else begin
      if (in_tvalid) begin
        got.func = func_t'(in_tdata[1:0]);
        got.seq  = in_tdata[33:2];
        predict_table(got);
      end
      if (gap_in > 0) begin
        in_tvalid <= 1'b0;
        gap_in    <= gap_in - 1;
      end else if (cmd_queue.size() > 0) begin
        nxt = cmd_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {6'd0, nxt.seq, nxt.func};
        gap_in    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted result, random stalls on ready
  int gap_out;
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      gap_out    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result kind %0d seq %h",
                           out_tdata[2:0], out_tdata[34:3]));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[2:0] !== want.kind)
            report($sformatf("kind %0d, want %0d", out_tdata[2:0], want.kind));
          if (out_tdata[34:3] !== want.seq)
            report($sformatf("seq %h, want %h", out_tdata[34:3], want.seq));
          if (out_tlast !== want.last)
            report($sformatf("last %b, want %b", out_tlast, want.last));
          if (out_tdata[39:35] !== 5'd0) report("nonzero pad in result");
        end
        gap_out <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        out_tready <= 1'b0;
      end else if (gap_out > 0) begin
        gap_out    <= gap_out - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c.func = FUNC_SEND;
      // narrow values give duplicates, wide ones cover every bit
      c.seq  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
      sent_pool.push_back(c.seq);
      if (sent_pool.size() > 32) void'(sent_pool.pop_front());
    end else if (pick < 60) begin
      c.func = FUNC_ACK;
      if (sent_pool.size() > 0 && $urandom_range(0, 3) != 0)
        c.seq = sent_pool[$urandom_range(0, sent_pool.size() - 1)];
      else
        c.seq = $urandom;
    end else if (pick < 97) begin
      c.func = FUNC_TICK;
      c.seq  = $urandom;
    end else begin
      c.func = FUNC_NONE;
      c.seq  = $urandom;
    end
    return c;
  endfunction

  // waits for the queue and the block to drain, then writes the timeout
  task automatic set_timeout(input logic [15:0] value);
    wait (cmd_queue.size() == 0 && !in_tvalid && expected_results.size() == 0);
    // a tick without resends may still be scanning
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    timeout_reg = value;
  endtask

  task automatic push(input func_t f, input logic [31:0] s);
    cmd_queue.push_back('{f, s});
  endtask

  initial begin
    errors      = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    pend_count  = 0;
    tick_now    = '0;
    timeout_reg = 16'd1000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: short timeout, fill past full, duplicates, unmatched ack, ticks
    set_timeout(16'd1);
    push(FUNC_ACK, 32'h0000_0000);
    push(FUNC_SEND, 32'hFFFF_FFFF);
    push(FUNC_SEND, 32'h0000_0000);
    push(FUNC_SEND, 32'h0000_0000);
    for (int i = 0; i < 14; i++) push(FUNC_SEND, 32'h1000 + i);
    push(FUNC_TICK, 32'hFFFF_FFFF);
    push(FUNC_TICK, 32'h0);
    push(FUNC_ACK, 32'h0000_0000);
    push(FUNC_ACK, 32'hFFFF_FFFF);
    push(FUNC_ACK, 32'hAAAA_5555);
    push(FUNC_NONE, 32'h5555_AAAA);
    push(FUNC_TICK, 32'h0);

    set_timeout(16'd65535);
    for (int i = 0; i < 60; i++) cmd_queue.push_back(random_cmd());
    set_timeout(16'd0);
    for (int i = 0; i < 60; i++) cmd_queue.push_back(random_cmd());
    set_timeout(16'd3);
    for (int i = 0; i < 150; i++) cmd_queue.push_back(random_cmd());
    set_timeout(16'($urandom_range(1, 12)));
    for (int i = 0; i < 150; i++) cmd_queue.push_back(random_cmd());

    wait (cmd_queue.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
